[hw/rtl/base64_encoder_line_wrap_assert.svh]
// Assertion macros for the base64 line-wrapping encoder.
`ifndef BASE64_ENCODER_LINE_WRAP_ASSERT_SVH
`define BASE64_ENCODER_LINE_WRAP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication under reset.
`define B64LW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b64lw: same-cycle check failed");
// Next-cycle implication under reset.
`define B64LW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b64lw: next-cycle check failed");
`else
`define B64LW_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define B64LW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/b64lw_pkg.sv]
// Shared types, constants and the alphabet function for the base64 encoder.
package b64lw_pkg;

    localparam logic [7:0] WRAP_RESET = 8'd72;
    localparam logic [7:0] CH_PAD     = 8'h3d;
    localparam logic [7:0] CH_CR      = 8'h0d;
    localparam logic [7:0] CH_LF      = 8'h0a;

    // Sequencer positions: break characters first, then the four body characters
    localparam logic [2:0] POS_CR    = 3'd0;
    localparam logic [2:0] POS_LF    = 3'd1;
    localparam logic [2:0] POS_BODY0 = 3'd2;
    localparam logic [2:0] POS_BODY1 = 3'd3;
    localparam logic [2:0] POS_BODY2 = 3'd4;
    localparam logic [2:0] POS_BODY3 = 3'd5;

    // One group's worth of output: optional CR LF then four characters
    typedef struct packed {
        logic            brk;
        logic [3:0][7:0] chars;
    } t_run;

    // Standard base64 alphabet
    function automatic logic [7:0] sym(input logic [5:0] v);
        logic [7:0] r;
        if (v < 6'd26) begin
            r = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            r = 8'h61 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            r = 8'h30 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            r = 8'h2b;
        end else begin
            r = 8'h2f;
        end
        return r;
    endfunction

endpackage

[hw/rtl/b64lw_planner.sv]
// Group assembly, line counting and character planning for each input byte.
module b64lw_planner import b64lw_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wrap_limit,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_produce,
    output logic       o_may_skip,
    output t_run       o_run
);

    logic [7:0]  r_wrap_limit;
    logic [1:0]  r_bytes_held;
    logic [15:0] r_held_bits;
    logic [7:0]  r_line_chars;

    logic [1:0]  n_bytes_held;
    logic [15:0] n_held_bits;
    logic [7:0]  n_line_chars;
    logic [23:0] w_group;
    logic        w_full;

    assign w_full = (r_bytes_held >= 2'd2);
    // A byte that neither completes a group nor ends a message emits nothing
    assign o_may_skip = !w_full && !i_last_byte;

    // Next state and planned characters
    always_comb begin
        n_bytes_held = r_bytes_held;
        n_held_bits  = r_held_bits;
        n_line_chars = r_line_chars;
        o_produce    = 1'b0;
        o_run        = '0;
        w_group      = {r_held_bits, i_data_byte};
        if (!w_full) begin
            if (r_bytes_held == 2'd0) begin
                n_held_bits  = {i_data_byte, 8'h00};
                n_bytes_held = 2'd1;
            end else begin
                n_held_bits  = r_held_bits | {8'h00, i_data_byte};
                n_bytes_held = 2'd2;
            end
            w_group = {n_held_bits, 8'h00};
            if (i_last_byte) begin
                // padded partial group
                o_produce      = 1'b1;
                o_run.brk      = (r_line_chars > r_wrap_limit);
                o_run.chars[0] = sym(w_group[23:18]);
                o_run.chars[1] = sym(w_group[17:12]);
                o_run.chars[2] = (n_bytes_held == 2'd1) ? CH_PAD : sym(w_group[11:6]);
                o_run.chars[3] = CH_PAD;
                n_bytes_held   = 2'd0;
                n_held_bits    = '0;
                n_line_chars   = '0;
            end
        end else begin
            // complete group
            o_produce      = 1'b1;
            o_run.brk      = (r_line_chars > r_wrap_limit);
            o_run.chars[0] = sym(w_group[23:18]);
            o_run.chars[1] = sym(w_group[17:12]);
            o_run.chars[2] = sym(w_group[11:6]);
            o_run.chars[3] = sym(w_group[5:0]);
            n_line_chars   = (o_run.brk ? 8'd0 : r_line_chars) + 8'd4;
            n_bytes_held   = 2'd0;
            n_held_bits    = '0;
            if (i_last_byte) begin
                n_line_chars = '0;
            end
        end
    end

    // Encoder state and limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_limit <= WRAP_RESET;
            r_bytes_held <= '0;
            r_held_bits  <= '0;
            r_line_chars <= '0;
        end else begin
            if (i_cfg_we) begin
                r_wrap_limit <= i_cfg_wrap_limit;
            end
            if (i_accept) begin
                r_bytes_held <= n_bytes_held;
                r_held_bits  <= n_held_bits;
                r_line_chars <= n_line_chars;
            end
        end
    end

endmodule

[hw/rtl/b64lw_serializer.sv]
// Run buffer and output register: sends planned characters one per cycle while the output is ready.
module b64lw_serializer import b64lw_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_run       i_run,
    output logic       o_buf_free,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_char,
    output logic       o_run_last
);

    logic       r_run_valid;
    t_run       r_run;
    logic [2:0] r_pos;
    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic       r_out_last;

    logic       w_step;
    logic [7:0] w_char;
    logic       w_run_end;

    // Move a character into the output register when it is empty or taken
    assign w_step     = r_run_valid && (!r_out_valid || i_out_ready);
    assign w_run_end  = (r_pos == POS_BODY3);
    assign o_buf_free = !r_run_valid || (w_step && w_run_end);

    always_comb begin
        case (r_pos)
            POS_CR:    w_char = CH_CR;
            POS_LF:    w_char = CH_LF;
            POS_BODY0: w_char = r_run.chars[0];
            POS_BODY1: w_char = r_run.chars[1];
            POS_BODY2: w_char = r_run.chars[2];
            POS_BODY3: w_char = r_run.chars[3];
            default:   w_char = r_run.chars[3];
        endcase
    end

    // Run buffer with position counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_valid <= 1'b0;
            r_pos       <= POS_CR;
        end else begin
            if (i_load) begin
                r_run_valid <= 1'b1;
                r_pos       <= i_run.brk ? POS_CR : POS_BODY0;
            end else if (w_step) begin
                if (w_run_end) begin
                    r_run_valid <= 1'b0;
                end
                r_pos <= r_pos + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_run <= i_run;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_char <= w_char;
            r_out_last <= w_run_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_run_last  = r_out_last;

endmodule

[hw/rtl/base64_encoder_line_wrap.sv]
// Top level of the streaming base64 encoder with CR LF line wrapping.
// The first character of an input's results goes through the run buffer and the output register.
// Characters leave one per cycle while i_out_ready is high; a byte that emits nothing is
// taken even while a run is being sent, and a byte that emits 4 or 6 characters holds the
// run buffer until its last character moves into the output register.
// Reset (synchronous, active low) clears group state, line count and queues; limit = 72.
`include "base64_encoder_line_wrap_assert.svh"
module base64_encoder_line_wrap import b64lw_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_wrap_limit,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_char,
    output logic       o_run_last
);

    logic w_accept;
    logic w_produce;
    logic w_may_skip;
    logic w_buf_free;
    t_run w_run;

    assign o_cfg_ready = 1'b1;
    // Bytes that emit nothing pass even while a run is still being sent
    assign o_in_ready  = w_buf_free || w_may_skip;
    assign w_accept    = i_in_valid && o_in_ready;

    b64lw_planner u_planner (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_valid),
        .i_cfg_wrap_limit (i_cfg_wrap_limit),
        .i_accept         (w_accept),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .o_produce        (w_produce),
        .o_may_skip       (w_may_skip),
        .o_run            (w_run)
    );

    b64lw_serializer u_serializer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_accept && w_produce),
        .i_run       (w_run),
        .o_buf_free  (w_buf_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_char  (o_out_char),
        .o_run_last  (o_run_last)
    );

    // A producing transaction only enters when the run buffer can take it
    `B64LW_ASSERT_IMPL(a_load_room, i_clk, i_rst_n, w_accept && w_produce, w_buf_free)
    // A run continues without a gap after a character that is not its last
    `B64LW_ASSERT_NEXT(a_run_cont, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_run_last, o_out_valid)

endmodule
